// File: design/vrp_pkg.sv
// Shared types, register codes and address folding for the video register port.
// No dependencies.
package vrp_pkg;

    typedef logic [1:0]  t_kind;
    typedef logic [2:0]  t_reg_idx;
    typedef logic [7:0]  t_byte;
    typedef logic [13:0] t_vaddr;
    typedef logic [14:0] t_raddr;
    typedef logic [8:0]  t_line;
    typedef logic [2:0]  t_mirror;

    localparam int VIDEO_MEM_DEPTH  = 16384;
    localparam int SPRITE_MEM_DEPTH = 256;
    localparam int CFG_ADDR_W       = 3;

    localparam t_kind KIND_READ  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_TICK  = 2'd2;

    localparam t_reg_idx REG_CTRL   = 3'd0;
    localparam t_reg_idx REG_MASK   = 3'd1;
    localparam t_reg_idx REG_STATUS = 3'd2;
    localparam t_reg_idx REG_SPR_AD = 3'd3;
    localparam t_reg_idx REG_SPR_DT = 3'd4;
    localparam t_reg_idx REG_SCROLL = 3'd5;
    localparam t_reg_idx REG_ADDR   = 3'd6;
    localparam t_reg_idx REG_DATA   = 3'd7;

    localparam t_mirror MIR_HORZ   = 3'd0;
    localparam t_mirror MIR_VERT   = 3'd1;
    localparam t_mirror MIR_LOWER  = 3'd2;
    localparam t_mirror MIR_UPPER  = 3'd3;

    localparam logic CFG_IDX_MIRROR = 1'b0;

    localparam t_line LINE_PRE     = 9'd0;
    localparam t_line LINE_VBL_SET = 9'd241;
    localparam t_line LINE_VBL_CLR = 9'd261;
    localparam t_line LINE_LAST    = 9'd262;

    localparam t_vaddr       PAL_BASE   = 14'h3F00;
    localparam t_vaddr       PAL_MASK   = 14'h3F1F;
    localparam logic [11:0]  PAL_SPLIT  = 12'hF00;
    localparam t_vaddr       STEP_ROW   = 14'd32;
    localparam t_vaddr       STEP_COL   = 14'd1;
    localparam t_byte        BYTE_NONE  = 8'hFF;

    function automatic t_vaddr nt_fold(t_vaddr a, t_mirror mode);
        t_vaddr b;
        b = a;
        unique case (mode)
            MIR_HORZ:  b = {a[13:12], 1'b0, a[11], a[9:0]};
            MIR_VERT:  b = {a[13:12], 1'b0, a[10], a[9:0]};
            MIR_LOWER: b = {a[13:12], 2'b00, a[9:0]};
            MIR_UPPER: b = {a[13:12], 2'b01, a[9:0]};
            default:   b = a;
        endcase
        return b;
    endfunction

    function automatic t_vaddr fold_addr(t_vaddr a, t_mirror mode);
        t_vaddr b;
        b = a;
        if (a[13:12] == 2'b10) begin
            b = nt_fold(a, mode);
        end else if (a[13:12] == 2'b11) begin
            if (a[11:0] < PAL_SPLIT) begin
                b = nt_fold({2'b10, a[11:0]}, mode);
            end else begin
                b = a & PAL_MASK;
                if (b[1:0] == 2'b00 && b[4]) begin
                    b[4] = 1'b0;
                end
            end
        end
        return b;
    endfunction

endpackage

// File: design/vrp_if.sv
// Request and response channel interfaces of the video register port.
// Depends on vrp_pkg.
interface vrp_req_if;
    logic              valid;
    logic              ready;
    vrp_pkg::t_kind    kind;
    vrp_pkg::t_reg_idx reg_index;
    vrp_pkg::t_byte    write_data;

    modport source (output valid, kind, reg_index, write_data, input ready);
    modport sink   (input valid, kind, reg_index, write_data, output ready);
endinterface

interface vrp_rsp_if;
    logic           valid;
    logic           ready;
    vrp_pkg::t_byte read_data;
    logic           read_valid;
    logic           nmi;
    logic           frame_end;

    modport source (output valid, read_data, read_valid, nmi, frame_end, input ready);
    modport sink   (input valid, read_data, read_valid, nmi, frame_end, output ready);
endinterface

// File: design/video_register_port_with_vram_unit.sv
// Video register port: CPU register file, scroll/address loading, video and sprite memory.
// A taken request enters the execute state, which waits for the registered read of the
// video and sprite RAMs, then registers the reply; no request is taken meanwhile.
// A request is taken only while the output register is empty or is drained in that cycle.
// Reset is synchronous; afterwards a sweep zeroes every word of both RAMs with the request
// channel not ready (configuration writes are still taken).
// Depends on vrp_pkg, vrp_if, vrp_ram.
module video_register_port_with_vram_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    vrp_req_if.sink                           i_req,
    vrp_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vrp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;
    typedef enum logic [1:0] {SRC_FIXED, SRC_SPR, SRC_VBUF, SRC_VPAL} t_src;

    t_state           r_state, n_state;
    t_src             r_src, n_src;
    vrp_pkg::t_mirror r_mirror;
    vrp_pkg::t_byte   r_ctrl, n_ctrl;
    vrp_pkg::t_byte   r_mask, n_mask;
    logic             r_vblank, n_vblank;
    logic             r_wio, n_wio;
    vrp_pkg::t_vaddr  r_cur, n_cur;
    vrp_pkg::t_raddr  r_reload, n_reload;
    logic [2:0]       r_fine_x, n_fine_x;
    logic             r_toggle, n_toggle;
    vrp_pkg::t_byte   r_rbuf, n_rbuf;
    vrp_pkg::t_byte   r_spr_addr, n_spr_addr;
    vrp_pkg::t_line   r_line, n_line;

    vrp_pkg::t_byte   r_pend_rd, n_pend_rd;
    logic             r_pend_rv, n_pend_rv;
    logic             r_pend_nmi, n_pend_nmi;
    logic             r_pend_fend, n_pend_fend;

    logic             r_out_valid, n_out_valid;
    vrp_pkg::t_byte   r_out_rd, n_out_rd;
    logic             r_out_rv, n_out_rv;
    logic             r_out_nmi, n_out_nmi;
    logic             r_out_fend, n_out_fend;

    logic             r_clr_busy;
    vrp_pkg::t_vaddr  r_clr_addr;

    logic             accept;
    logic             cfg_wr;
    vrp_pkg::t_vaddr  vaddr_fold;
    vrp_pkg::t_vaddr  cur_step;
    logic             vram_we, spr_we;
    vrp_pkg::t_vaddr  vram_addr;
    vrp_pkg::t_byte   spr_ram_addr;
    vrp_pkg::t_byte   vram_wdata, spr_wdata;
    vrp_pkg::t_byte   vram_q, spr_q;
    vrp_pkg::t_byte   data;

    assign i_req.ready = (r_state == ST_IDLE) && !r_clr_busy
                         && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign data        = i_req.write_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == vrp_pkg::CFG_IDX_MIRROR);
    assign prdata = (paddr[2] == vrp_pkg::CFG_IDX_MIRROR) ? {29'd0, r_mirror} : 32'd0;

    assign vaddr_fold = vrp_pkg::fold_addr(r_cur, r_mirror);
    assign cur_step   = r_cur + (r_ctrl[2] ? vrp_pkg::STEP_ROW : vrp_pkg::STEP_COL);

    // RAM ports: clearing sweep, else the data-port / sprite-port access of the request
    assign vram_addr    = r_clr_busy ? r_clr_addr : vaddr_fold;
    assign vram_wdata   = r_clr_busy ? 8'd0 : data;
    assign vram_we      = r_clr_busy || (accept && i_req.kind == vrp_pkg::KIND_WRITE
                                         && i_req.reg_index == vrp_pkg::REG_DATA);
    assign spr_ram_addr = r_clr_busy ? r_clr_addr[7:0] : r_spr_addr;
    assign spr_wdata    = r_clr_busy ? 8'd0 : data;
    assign spr_we       = r_clr_busy || (accept && i_req.kind == vrp_pkg::KIND_WRITE
                                         && i_req.reg_index == vrp_pkg::REG_SPR_DT);

    vrp_ram #(
        .WIDTH (8),
        .DEPTH (vrp_pkg::VIDEO_MEM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_addr  (vram_addr),
        .i_wdata (vram_wdata),
        .o_rdata (vram_q)
    );

    vrp_ram #(
        .WIDTH (8),
        .DEPTH (vrp_pkg::SPRITE_MEM_DEPTH)
    ) u_spr_ram (
        .i_clk   (i_clk),
        .i_we    (spr_we),
        .i_addr  (spr_ram_addr),
        .i_wdata (spr_wdata),
        .o_rdata (spr_q)
    );

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_ctrl      = r_ctrl;
        n_mask      = r_mask;
        n_vblank    = r_vblank;
        n_wio       = r_wio;
        n_cur       = r_cur;
        n_reload    = r_reload;
        n_fine_x    = r_fine_x;
        n_toggle    = r_toggle;
        n_rbuf      = r_rbuf;
        n_spr_addr  = r_spr_addr;
        n_line      = r_line;
        n_pend_rd   = r_pend_rd;
        n_pend_rv   = r_pend_rv;
        n_pend_nmi  = r_pend_nmi;
        n_pend_fend = r_pend_fend;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_rd    = r_out_rd;
        n_out_rv    = r_out_rv;
        n_out_nmi   = r_out_nmi;
        n_out_fend  = r_out_fend;

        if (accept) begin
            n_state     = ST_EXEC;
            n_src       = SRC_FIXED;
            n_pend_rd   = vrp_pkg::BYTE_NONE;
            n_pend_rv   = 1'b0;
            n_pend_nmi  = 1'b0;
            n_pend_fend = 1'b0;
            unique case (i_req.kind)
                vrp_pkg::KIND_READ: begin
                    unique case (i_req.reg_index)
                        vrp_pkg::REG_STATUS: begin
                            n_pend_rd = {r_vblank, 2'b00, r_wio, 4'b0000};
                            n_pend_rv = 1'b1;
                            n_vblank  = 1'b0;
                            n_toggle  = 1'b1;
                            n_rbuf    = vrp_pkg::BYTE_NONE;
                        end
                        vrp_pkg::REG_SPR_DT: begin
                            n_src     = SRC_SPR;
                            n_pend_rv = 1'b1;
                        end
                        vrp_pkg::REG_DATA: begin
                            n_src     = (vaddr_fold < vrp_pkg::PAL_BASE) ? SRC_VBUF : SRC_VPAL;
                            n_pend_rv = 1'b1;
                            n_cur     = cur_step;
                        end
                        default: begin
                        end
                    endcase
                end
                vrp_pkg::KIND_WRITE: begin
                    unique case (i_req.reg_index)
                        vrp_pkg::REG_CTRL: begin
                            n_pend_nmi = !r_ctrl[7] && data[7] && r_vblank;
                            n_ctrl     = data;
                        end
                        vrp_pkg::REG_MASK:   n_mask     = data;
                        vrp_pkg::REG_SPR_AD: n_spr_addr = data;
                        vrp_pkg::REG_SPR_DT: n_spr_addr = r_spr_addr + 8'd1;
                        vrp_pkg::REG_SCROLL: begin
                            if (r_toggle) begin
                                n_fine_x       = data[2:0];
                                n_reload[4:0]  = data[7:3];
                            end else begin
                                n_reload[14:12] = data[2:0];
                                n_reload[9:5]   = data[7:3];
                            end
                            n_toggle = !r_toggle;
                        end
                        vrp_pkg::REG_ADDR: begin
                            if (r_toggle) begin
                                n_reload[9:8]   = data[1:0];
                                n_reload[13:12] = data[5:4];
                                n_ctrl[1:0]     = data[3:2];
                            end else begin
                                n_reload[7:0] = data;
                                n_cur = {r_reload[13:12], r_ctrl[1:0], r_reload[9:8], data};
                            end
                            n_toggle = !r_toggle;
                        end
                        vrp_pkg::REG_DATA:   n_cur = cur_step;
                        default: begin
                        end
                    endcase
                end
                vrp_pkg::KIND_TICK: begin
                    if (r_line == vrp_pkg::LINE_PRE) begin
                        if (r_mask[4:3] != 2'b00) begin
                            n_cur = {r_reload[13:12], r_ctrl[1], r_cur[10],
                                     r_reload[9:5], r_cur[4:0]};
                            n_wio = 1'b1;
                        end
                    end else if (r_line == vrp_pkg::LINE_VBL_SET) begin
                        n_vblank   = 1'b1;
                        n_wio      = 1'b0;
                        n_pend_nmi = r_ctrl[7];
                    end else if (r_line == vrp_pkg::LINE_VBL_CLR) begin
                        n_vblank = 1'b0;
                    end
                    if (r_line == vrp_pkg::LINE_LAST) begin
                        n_line      = '0;
                        n_pend_fend = 1'b1;
                    end else begin
                        n_line = r_line + 9'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (r_state == ST_EXEC && (!r_out_valid || o_rsp.ready)) begin
            n_state     = ST_IDLE;
            n_out_valid = 1'b1;
            n_out_rv    = r_pend_rv;
            n_out_nmi   = r_pend_nmi;
            n_out_fend  = r_pend_fend;
            unique case (r_src)
                SRC_FIXED: n_out_rd = r_pend_rd;
                SRC_SPR:   n_out_rd = spr_q;
                SRC_VBUF: begin
                    n_out_rd = r_rbuf;
                    n_rbuf   = vram_q;
                end
                SRC_VPAL:  n_out_rd = vram_q;
                default:   n_out_rd = r_pend_rd;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mirror    <= vrp_pkg::MIR_VERT;
            r_ctrl      <= '0;
            r_mask      <= '0;
            r_vblank    <= 1'b0;
            r_wio       <= 1'b0;
            r_cur       <= '0;
            r_reload    <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b1;
            r_rbuf      <= vrp_pkg::BYTE_NONE;
            r_spr_addr  <= '0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_ctrl      <= n_ctrl;
            r_mask      <= n_mask;
            r_vblank    <= n_vblank;
            r_wio       <= n_wio;
            r_cur       <= n_cur;
            r_reload    <= n_reload;
            r_fine_x    <= n_fine_x;
            r_toggle    <= n_toggle;
            r_rbuf      <= n_rbuf;
            r_spr_addr  <= n_spr_addr;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_mirror <= pwdata[2:0];
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 14'd1;
                if (r_clr_addr == 14'h3FFF) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
        r_src       <= n_src;
        r_pend_rd   <= n_pend_rd;
        r_pend_rv   <= n_pend_rv;
        r_pend_nmi  <= n_pend_nmi;
        r_pend_fend <= n_pend_fend;
        r_out_rd    <= n_out_rd;
        r_out_rv    <= n_out_rv;
        r_out_nmi   <= n_out_nmi;
        r_out_fend  <= n_out_fend;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_out_rd;
    assign o_rsp.read_valid = r_out_rv;
    assign o_rsp.nmi        = r_out_nmi;
    assign o_rsp.frame_end  = r_out_fend;

endmodule

// File: design/vrp_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module vrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the video register port: directed register, sprite, video and
// frame checks, then randomised CPU traffic under each named mirroring mode and undefined codes.
// Depends on vrp_pkg, vrp_if and the video_register_port_with_vram_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam vrp_pkg::t_kind   KIND_VOID    = 2'd3;
    localparam vrp_pkg::t_mirror MIR_FOUR     = 3'd4;
    localparam vrp_pkg::t_mirror MIR_WILD     = 3'd7;
    localparam int               MAX_IDLE     = 16;
    localparam int               RANDOM_ITEMS = 385;
    localparam int               PHASES       = 7;

    typedef struct packed {
        vrp_pkg::t_byte rdata;
        logic           rvalid;
        logic           nmi;
        logic           fend;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [vrp_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vrp_req_if req_ch ();
    vrp_rsp_if rsp_ch ();

    video_register_port_with_vram_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the port state
    vrp_pkg::t_mirror mir_mode;
    vrp_pkg::t_byte   ctrl_r;
    vrp_pkg::t_byte   mask_r;
    logic             vbl;
    logic             wr_ign;
    vrp_pkg::t_vaddr  vaddr;
    vrp_pkg::t_raddr  taddr;
    logic [2:0]       fine_x;
    logic             latch_first;
    vrp_pkg::t_byte   rd_buf;
    vrp_pkg::t_byte   spr_ptr;
    vrp_pkg::t_line   line_no;
    vrp_pkg::t_byte   vram [vrp_pkg::VIDEO_MEM_DEPTH];
    vrp_pkg::t_byte   oam  [vrp_pkg::SPRITE_MEM_DEPTH];

    t_reply awaited_replies [$];
    int     n_requests = 0;
    int     n_replies  = 0;
    int     n_bad      = 0;
    int     n_nmi      = 0;
    int     n_frames   = 0;
    int     n_settings = 0;
    bit     req_live   = 1'b0;
    bit     tx_idle    = 1'b1;
    bit     rx_idle    = 1'b1;

    function automatic void shadow_reset();
        mir_mode    = vrp_pkg::MIR_VERT;
        ctrl_r      = '0;
        mask_r      = '0;
        vbl         = 1'b0;
        wr_ign      = 1'b0;
        vaddr       = '0;
        taddr       = '0;
        fine_x      = '0;
        latch_first = 1'b1;
        rd_buf      = vrp_pkg::BYTE_NONE;
        spr_ptr     = '0;
        line_no     = vrp_pkg::LINE_PRE;
        foreach (vram[i]) vram[i] = '0;
        foreach (oam[i]) oam[i] = '0;
    endfunction

    function automatic vrp_pkg::t_vaddr nt_mirror(vrp_pkg::t_vaddr n);
        vrp_pkg::t_vaddr m;
        m = n;
        case (mir_mode)
            vrp_pkg::MIR_HORZ: begin
                m[10] = n[11];
                m[11] = 1'b0;
            end
            vrp_pkg::MIR_VERT:  m[11]    = 1'b0;
            vrp_pkg::MIR_LOWER: m[11:10] = 2'b00;
            vrp_pkg::MIR_UPPER: m[11:10] = 2'b01;
            default:            m        = n;
        endcase
        return m;
    endfunction

    function automatic vrp_pkg::t_vaddr vram_index(vrp_pkg::t_vaddr a);
        vrp_pkg::t_vaddr p;
        if (a[13:12] == 2'b11 && a[11:8] == 4'hF) begin
            p = a & vrp_pkg::PAL_MASK;
            if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
            return p;
        end
        if (a[13]) return nt_mirror({2'b10, a[11:0]});
        return a;
    endfunction

    function automatic void step_vaddr();
        vaddr = vaddr + (ctrl_r[2] ? vrp_pkg::STEP_ROW : vrp_pkg::STEP_COL);
    endfunction

    function automatic t_reply port_reply(vrp_pkg::t_kind k, vrp_pkg::t_reg_idx r,
                                          vrp_pkg::t_byte d);
        t_reply          rep;
        vrp_pkg::t_vaddr a;
        rep = '{rdata: vrp_pkg::BYTE_NONE, rvalid: 1'b0, nmi: 1'b0, fend: 1'b0};
        case (k)
            vrp_pkg::KIND_READ: begin
                case (r)
                    vrp_pkg::REG_STATUS: begin
                        rep.rdata   = {vbl, 2'b00, wr_ign, 4'h0};
                        rep.rvalid  = 1'b1;
                        vbl         = 1'b0;
                        latch_first = 1'b1;
                        rd_buf      = vrp_pkg::BYTE_NONE;
                    end
                    vrp_pkg::REG_SPR_DT: begin
                        rep.rdata  = oam[spr_ptr];
                        rep.rvalid = 1'b1;
                    end
                    vrp_pkg::REG_DATA: begin
                        a = vram_index(vaddr);
                        step_vaddr();
                        if (a < vrp_pkg::PAL_BASE) begin
                            rep.rdata = rd_buf;
                            rd_buf    = vram[a];
                        end else begin
                            rep.rdata = vram[a];
                        end
                        rep.rvalid = 1'b1;
                    end
                    default: ;
                endcase
            end
            vrp_pkg::KIND_WRITE: begin
                case (r)
                    vrp_pkg::REG_CTRL: begin
                        if (!ctrl_r[7] && d[7] && vbl) rep.nmi = 1'b1;
                        ctrl_r = d;
                    end
                    vrp_pkg::REG_MASK:   mask_r  = d;
                    vrp_pkg::REG_SPR_AD: spr_ptr = d;
                    vrp_pkg::REG_SPR_DT: begin
                        oam[spr_ptr] = d;
                        spr_ptr      = spr_ptr + 8'd1;
                    end
                    vrp_pkg::REG_SCROLL: begin
                        if (latch_first) begin
                            fine_x     = d[2:0];
                            taddr[4:0] = d[7:3];
                        end else begin
                            taddr[14:12] = d[2:0];
                            taddr[9:5]   = d[7:3];
                        end
                        latch_first = ~latch_first;
                    end
                    vrp_pkg::REG_ADDR: begin
                        if (latch_first) begin
                            taddr[9:8]   = d[1:0];
                            taddr[13:12] = d[5:4];
                            ctrl_r[1:0]  = d[3:2];
                        end else begin
                            taddr[7:0] = d;
                            vaddr      = {taddr[13:12], ctrl_r[1:0], taddr[9:8], d};
                        end
                        latch_first = ~latch_first;
                    end
                    vrp_pkg::REG_DATA: begin
                        vram[vram_index(vaddr)] = d;
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            vrp_pkg::KIND_TICK: begin
                if (line_no == vrp_pkg::LINE_PRE) begin
                    if (mask_r[4] || mask_r[3]) begin
                        vaddr[13:12] = taddr[13:12];
                        vaddr[11]    = ctrl_r[1];
                        vaddr[9:5]   = taddr[9:5];
                        wr_ign       = 1'b1;
                    end
                end else if (line_no == vrp_pkg::LINE_VBL_SET) begin
                    vbl    = 1'b1;
                    wr_ign = 1'b0;
                    if (ctrl_r[7]) rep.nmi = 1'b1;
                end else if (line_no == vrp_pkg::LINE_VBL_CLR) begin
                    vbl = 1'b0;
                end
                if (line_no == vrp_pkg::LINE_LAST) begin
                    line_no  = vrp_pkg::LINE_PRE;
                    rep.fend = 1'b1;
                end else begin
                    line_no = line_no + 9'd1;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    task automatic send(vrp_pkg::t_kind k, vrp_pkg::t_reg_idx r, vrp_pkg::t_byte d);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            if (req_live) begin
                req_ch.valid <= 1'b0;
                req_live = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= k;
        req_ch.reg_index  <= r;
        req_ch.write_data <= d;
        req_live = 1'b1;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        awaited_replies.push_back(port_reply(k, r, d));
        n_requests++;
    endtask

    task automatic drain();
        if (req_live) begin
            req_ch.valid <= 1'b0;
            req_live = 1'b0;
        end
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mirroring(vrp_pkg::t_mirror m);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {vrp_pkg::CFG_IDX_MIRROR, 2'b00};
        pwdata  <= {29'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mir_mode = m;
        n_settings++;
    endtask

    // status read resets the toggle, then the two address writes
    task automatic point_vaddr(vrp_pkg::t_vaddr a);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_STATUS, 8'h00);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_ADDR, {2'($urandom), a[13:8]});
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_ADDR, a[7:0]);
    endtask

    function automatic vrp_pkg::t_vaddr pick_vaddr();
        case ($urandom_range(0, 3))
            0:       return {2'b10, 12'($urandom)};
            1:       return {6'h3F, 8'($urandom)};
            2:       return {2'b11, 12'($urandom)};
            default: return vrp_pkg::t_vaddr'($urandom);
        endcase
    endfunction

    task automatic test_register_map();
        for (int i = 0; i < 8; i++) send(vrp_pkg::KIND_READ, vrp_pkg::t_reg_idx'(i), 8'h00);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_STATUS, 8'hFF);
        send(KIND_VOID, vrp_pkg::REG_DATA, 8'h5A);
    endtask

    task automatic test_sprite_port();
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SPR_AD, 8'hFF);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SPR_DT, 8'hA5);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SPR_AD, 8'hFF);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_SPR_DT, 8'h00);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_SPR_DT, 8'h00);
    endtask

    task automatic test_video_port();
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, 8'h04);
        point_vaddr(14'h3F10);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_DATA, 8'h3F);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, 8'h00);
        point_vaddr(vrp_pkg::PAL_BASE);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_DATA, 8'h00);
        point_vaddr(14'h23FF);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_DATA, 8'hFF);
        point_vaddr(14'h3FFF);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_DATA, 8'h00);
        point_vaddr(14'h23FF);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_DATA, 8'h00);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_DATA, 8'h00);
    endtask

    // one whole frame: pre-render reload, vblank NMI, NMI on control write, frame end
    task automatic test_frame_timing();
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_STATUS, 8'h00);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SCROLL, 8'hFF);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SCROLL, 8'hFF);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_MASK, 8'h18);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, 8'h82);
        while (line_no != vrp_pkg::LINE_VBL_SET + 9'd1)
            send(vrp_pkg::KIND_TICK, vrp_pkg::REG_CTRL, 8'h00);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, 8'h00);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, 8'h80);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_STATUS, 8'h00);
        send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, 8'h00);
        while (line_no != vrp_pkg::LINE_PRE) send(vrp_pkg::KIND_TICK, vrp_pkg::REG_DATA, 8'hFF);
        send(vrp_pkg::KIND_TICK, vrp_pkg::REG_DATA, 8'h00);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_STATUS, 8'h00);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_DATA, 8'h00);
        send(vrp_pkg::KIND_READ, vrp_pkg::REG_DATA, 8'h00);
    endtask

    task automatic random_burst();
        int             pick;
        vrp_pkg::t_byte b;
        pick = $urandom_range(0, 99);
        b    = vrp_pkg::t_byte'($urandom);
        if (pick < 25) begin
            repeat ($urandom_range(1, 24))
                send(vrp_pkg::KIND_TICK, vrp_pkg::t_reg_idx'($urandom),
                     vrp_pkg::t_byte'($urandom));
        end else if (pick < 45) begin
            point_vaddr(pick_vaddr());
            repeat ($urandom_range(1, 6))
                send($urandom_range(0, 1) ? vrp_pkg::KIND_WRITE : vrp_pkg::KIND_READ,
                     vrp_pkg::REG_DATA, vrp_pkg::t_byte'($urandom));
        end else if (pick < 55) begin
            send(vrp_pkg::KIND_READ, vrp_pkg::REG_STATUS, 8'h00);
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SCROLL, vrp_pkg::t_byte'($urandom));
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SCROLL, vrp_pkg::t_byte'($urandom));
        end else if (pick < 65) begin
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SPR_AD, b);
            repeat ($urandom_range(1, 4))
                send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SPR_DT, vrp_pkg::t_byte'($urandom));
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_SPR_AD, b);
            repeat ($urandom_range(1, 3))
                send(vrp_pkg::KIND_READ, vrp_pkg::REG_SPR_DT, vrp_pkg::t_byte'($urandom));
        end else if (pick < 75) begin
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_CTRL, b);
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_MASK, vrp_pkg::t_byte'($urandom));
        end else if (pick < 85) begin
            send(vrp_pkg::KIND_READ, vrp_pkg::REG_STATUS, b);
        end else if (pick < 95) begin
            send(vrp_pkg::t_kind'($urandom), vrp_pkg::t_reg_idx'($urandom), b);
        end else if (pick < 98) begin
            send(vrp_pkg::KIND_WRITE, vrp_pkg::REG_ADDR, b);
            send($urandom_range(0, 1) ? vrp_pkg::KIND_WRITE : vrp_pkg::KIND_READ,
                 vrp_pkg::REG_DATA, vrp_pkg::t_byte'($urandom));
        end else begin
            drain();
        end
    endtask

    task automatic test_random_traffic();
        vrp_pkg::t_mirror plan [PHASES];
        int               goal;
        plan = '{vrp_pkg::MIR_HORZ, MIR_FOUR, vrp_pkg::MIR_LOWER, vrp_pkg::MIR_UPPER,
                 MIR_WILD, MIR_WILD, vrp_pkg::MIR_VERT};
        plan[5] = vrp_pkg::t_mirror'($urandom_range(MIR_FOUR + 1, MIR_WILD));
        for (int p = 0; p < PHASES; p++) begin
            set_mirroring(plan[p]);
            tx_idle = (p % 3 != 0);
            rx_idle = (p % 3 != 1);
            goal    = n_requests + RANDOM_ITEMS / PHASES;
            while (n_requests < goal) random_burst();
        end
    endtask

    initial begin : reply_check
        t_reply want;
        t_reply got;
        int     stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
            got.rdata  = rsp_ch.read_data;
            got.rvalid = rsp_ch.read_valid;
            got.nmi    = rsp_ch.nmi;
            got.fend   = rsp_ch.frame_end;
            n_replies++;
            if (got.nmi === 1'b1) n_nmi++;
            if (got.fend === 1'b1) n_frames++;
            if (awaited_replies.size() == 0) begin
                if (n_bad < 10) $display("%0t: unexpected reply, data %02h", $time, got.rdata);
                n_bad++;
            end else begin
                want = awaited_replies.pop_front();
                if (got.rdata !== want.rdata || got.rvalid !== want.rvalid
                        || got.nmi !== want.nmi || got.fend !== want.fend) begin
                    if (n_bad < 10)
                        $display("%0t: mismatch data %02h/%02h valid %b/%b nmi %b/%b end %b/%b",
                                 $time, want.rdata, got.rdata, want.rvalid, got.rvalid,
                                 want.nmi, got.nmi, want.fend, got.fend);
                    n_bad++;
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = vrp_pkg::KIND_READ;
        req_ch.reg_index  = vrp_pkg::REG_CTRL;
        req_ch.write_data = '0;
        shadow_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_sprite_port();
        test_video_port();
        test_frame_timing();
        test_random_traffic();
        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests and %0d replies over %0d mirroring settings,",
                 n_requests, n_replies, n_settings);
        $display("with %0d NMI pulses and %0d frame ends seen.", n_nmi, n_frames);
        if (n_bad == 0 && awaited_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d replies outstanding", awaited_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
design/vrp_pkg.sv
design/vrp_if.sv
design/vrp_ram.sv
design/video_register_port_with_vram_unit.sv
tb/tb_top.sv
